### rtl/gbre_pkg.sv
// ----------------------------------------------------------------------------
// gbre_pkg
// Shared types and constants of the glyph bitmap run extractor.
// ----------------------------------------------------------------------------
package gbre_pkg;

  localparam int MAX_GLYPH_WIDTH  = 128;
  localparam int MAX_GLYPH_HEIGHT = 128;

  localparam int BYTE_BITS = 8;

  // Clamped width and height, column and run start, row index
  localparam int W_W   = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int RB_W  = $clog2(MAX_GLYPH_WIDTH);
  localparam int ROW_W = $clog2(MAX_GLYPH_HEIGHT);

  // Column plus bit offset, one bit above the width range
  localparam int SCAN_W = W_W + 1;

  // Commands released per byte, and the scratch list of one byte
  localparam int CMDS_PER_REC = 4;
  localparam int CMD_IDX_W    = $clog2(CMDS_PER_REC);
  localparam int BUF_CAP      = 6;
  localparam int BUF_IDX_W    = $clog2(BUF_CAP);
  localparam int CNT_W        = $clog2(BUF_CAP + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [QPTR_W-1:0] QLAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd4;

  localparam logic [7:0] RESET_GLYPH_WIDTH  = 8'd8;
  localparam logic [7:0] RESET_GLYPH_HEIGHT = 8'd8;

  typedef struct packed {
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        fill_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bitmap_byte;
    logic       glyph_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [7:0]         rect_length;
    logic [15:0]        rect_color;
    logic               last_of_byte;
  } out_t;

  // Commands of one byte, in order; the last one carries last_of_byte
  typedef struct packed {
    out_t [CMDS_PER_REC-1:0] cmd;
  } rec_t;

endpackage

### rtl/gbre_front.sv
// ----------------------------------------------------------------------------
// gbre_front
// Scans one bitmap byte per cycle while the queue has room, tracks column, row
// and the open run, and builds the fill commands of that byte, holding a fifth one over.
// ----------------------------------------------------------------------------
module gbre_front (
  input  logic            clk,
  input  logic            rst,
  input  gbre_pkg::cfg_t  cfg,
  input  gbre_pkg::in_t   item,
  input  logic            accept,
  output logic            wr_en,
  output gbre_pkg::rec_t  wr_rec
);

  logic [gbre_pkg::W_W-1:0]   column;
  logic [gbre_pkg::ROW_W-1:0] row_index;
  logic                       run_open;
  logic [gbre_pkg::RB_W-1:0]  run_begin;
  logic                       slot_valid;
  gbre_pkg::out_t             slot;

  logic [gbre_pkg::W_W-1:0]   column_next;
  logic [gbre_pkg::ROW_W-1:0] row_index_next;
  logic                       run_open_next;
  logic [gbre_pkg::RB_W-1:0]  run_begin_next;
  logic                       slot_valid_next;
  gbre_pkg::out_t             slot_next;

  logic [gbre_pkg::W_W-1:0]   w;
  logic [gbre_pkg::H_W-1:0]   h;
  gbre_pkg::out_t             bufc [gbre_pkg::BUF_CAP];
  logic [gbre_pkg::CNT_W-1:0] cnt;
  logic [gbre_pkg::CNT_W-1:0] n_out;

  function automatic gbre_pkg::out_t make_cmd(input gbre_pkg::cfg_t cf,
                                             input logic [gbre_pkg::RB_W-1:0] start,
                                             input logic [gbre_pkg::W_W-1:0] len,
                                             input logic [gbre_pkg::ROW_W-1:0] row);
    gbre_pkg::out_t r;
    r.rect_x       = cf.origin_x + $signed(16'(start));
    r.rect_y       = cf.origin_y + $signed(16'(row));
    r.rect_length  = 8'(len);
    r.rect_color   = cf.fill_color;
    r.last_of_byte = 1'b0;
    return r;
  endfunction

  // Clamp the geometry to the supported maximum
  always_comb begin
    w = (32'(cfg.glyph_width) > gbre_pkg::MAX_GLYPH_WIDTH) ?
        gbre_pkg::W_W'(gbre_pkg::MAX_GLYPH_WIDTH) : gbre_pkg::W_W'(cfg.glyph_width);
    h = (32'(cfg.glyph_height) > gbre_pkg::MAX_GLYPH_HEIGHT) ?
        gbre_pkg::H_W'(gbre_pkg::MAX_GLYPH_HEIGHT) : gbre_pkg::H_W'(cfg.glyph_height);
  end

  always_comb begin
    logic [gbre_pkg::W_W-1:0]    col_s;
    logic [gbre_pkg::ROW_W-1:0]  row_s;
    logic                        open_s;
    logic [gbre_pkg::RB_W-1:0]   begin_s;
    logic [gbre_pkg::SCAN_W-1:0] c;
    logic [gbre_pkg::SCAN_W-1:0] len_c;
    logic                        px;
    logic                        row_end;
    logic [gbre_pkg::W_W-1:0]    end_len;
    logic [gbre_pkg::H_W-1:0]    row_inc;

    col_s   = item.glyph_start ? '0 : column;
    row_s   = item.glyph_start ? '0 : row_index;
    open_s  = item.glyph_start ? 1'b0 : run_open;
    begin_s = item.glyph_start ? '0 : run_begin;
    c       = '0;
    len_c   = '0;
    px      = 1'b0;
    cnt     = '0;
    for (int k = 0; k < gbre_pkg::BUF_CAP; k++) bufc[k] = '0;

    // A command held over from the previous byte goes out first
    if (slot_valid) begin
      bufc[0] = slot;
      cnt     = gbre_pkg::CNT_W'(1);
    end

    for (int b = 0; b < gbre_pkg::BYTE_BITS; b++) begin
      c  = gbre_pkg::SCAN_W'(col_s) + gbre_pkg::SCAN_W'(b);
      px = item.bitmap_byte[gbre_pkg::BYTE_BITS-1-b];
      if (c < gbre_pkg::SCAN_W'(w)) begin
        if (px && !open_s) begin
          open_s  = 1'b1;
          begin_s = gbre_pkg::RB_W'(c);
        end else if (!px && open_s) begin
          len_c = c - gbre_pkg::SCAN_W'(begin_s);
          if (cnt < gbre_pkg::CNT_W'(gbre_pkg::BUF_CAP)) begin
            bufc[cnt[gbre_pkg::BUF_IDX_W-1:0]] =
              make_cmd(cfg, begin_s, gbre_pkg::W_W'(len_c), row_s);
            cnt = cnt + gbre_pkg::CNT_W'(1);
          end
          open_s = 1'b0;
        end
      end
    end

    // Row end: close the open run, at least one pixel long
    row_end = (gbre_pkg::SCAN_W'(col_s) + gbre_pkg::SCAN_W'(gbre_pkg::BYTE_BITS)) >=
              gbre_pkg::SCAN_W'(w);
    end_len = (w > gbre_pkg::W_W'(begin_s)) ? (w - gbre_pkg::W_W'(begin_s))
                                             : gbre_pkg::W_W'(1);
    row_inc = gbre_pkg::H_W'(row_s) + gbre_pkg::H_W'(1);

    if (row_end && open_s) begin
      if (cnt < gbre_pkg::CNT_W'(gbre_pkg::BUF_CAP)) begin
        bufc[cnt[gbre_pkg::BUF_IDX_W-1:0]] = make_cmd(cfg, begin_s, end_len, row_s);
        cnt = cnt + gbre_pkg::CNT_W'(1);
      end
      open_s = 1'b0;
    end

    if (row_end) begin
      column_next    = '0;
      row_index_next = (row_inc >= h) ? '0 : gbre_pkg::ROW_W'(row_inc);
    end else begin
      column_next    = gbre_pkg::W_W'(gbre_pkg::SCAN_W'(col_s) +
                                      gbre_pkg::SCAN_W'(gbre_pkg::BYTE_BITS));
      row_index_next = row_s;
    end
    run_open_next  = open_s;
    run_begin_next = begin_s;

    n_out = (cnt > gbre_pkg::CNT_W'(gbre_pkg::CMDS_PER_REC)) ?
            gbre_pkg::CNT_W'(gbre_pkg::CMDS_PER_REC) : cnt;

    slot_valid_next = cnt > gbre_pkg::CNT_W'(gbre_pkg::CMDS_PER_REC);
    slot_next       = bufc[gbre_pkg::CMDS_PER_REC];

    for (int k = 0; k < gbre_pkg::CMDS_PER_REC; k++) begin
      wr_rec.cmd[k]              = bufc[k];
      wr_rec.cmd[k].last_of_byte = (gbre_pkg::CNT_W'(k + 1) == n_out);
    end
    wr_en = accept && (cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row_index  <= '0;
      run_open   <= 1'b0;
      run_begin  <= '0;
      slot_valid <= 1'b0;
    end else if (accept) begin
      column     <= column_next;
      row_index  <= row_index_next;
      run_open   <= run_open_next;
      run_begin  <= run_begin_next;
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot_valid_next) begin
      slot <= slot_next;
    end
  end

endmodule

### rtl/gbre_queue.sv
// ----------------------------------------------------------------------------
// gbre_queue
// Short queue of per-byte command records between scanner and output side.
// ----------------------------------------------------------------------------
module gbre_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  gbre_pkg::rec_t  wr_rec,
  input  logic            rd_en,
  output gbre_pkg::rec_t  head,
  output logic            head_valid,
  output logic            full
);

  gbre_pkg::rec_t              mem [gbre_pkg::QUEUE_DEPTH];
  logic [gbre_pkg::QPTR_W-1:0] wr_ptr;
  logic [gbre_pkg::QPTR_W-1:0] rd_ptr;
  logic [gbre_pkg::QCNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == gbre_pkg::QCNT_W'(gbre_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == gbre_pkg::QLAST_PTR) ? '0 : wr_ptr + gbre_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == gbre_pkg::QLAST_PTR) ? '0 : rd_ptr + gbre_pkg::QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + gbre_pkg::QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - gbre_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= gbre_pkg::QCNT_W'(gbre_pkg::QUEUE_DEPTH))
    else $error("record queue count past depth");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + gbre_pkg::QCNT_W'(1)))
    else $error("record write without count growth");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !rd_en) |=> $stable(head))
    else $error("head record changed while not read");

endmodule

### rtl/gbre_back.sv
// ----------------------------------------------------------------------------
// gbre_back
// Hands out the commands of the head record one transaction at a time.
// ----------------------------------------------------------------------------
module gbre_back (
  input  logic            clk,
  input  logic            rst,
  input  gbre_pkg::rec_t  head,
  input  logic            head_valid,
  input  logic            pop,
  output gbre_pkg::out_t  rect_item,
  output logic            empty,
  output logic            rd_en
);

  logic [gbre_pkg::CMD_IDX_W-1:0] idx;
  logic                           take;

  assign rect_item = head.cmd[idx];
  assign empty     = !head_valid;
  assign take      = pop && head_valid;
  // Retire the record with its last command
  assign rd_en     = take && rect_item.last_of_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (rd_en) begin
      idx <= '0;
    end else if (take) begin
      idx <= idx + gbre_pkg::CMD_IDX_W'(1);
    end
  end

endmodule

### rtl/glyph_bitmap_run_extractor.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_run_extractor
// Turns a 1-bit-per-pixel glyph bitmap into one-pixel-high fill commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive bitmap_item and raise push; the byte is taken on
//   a clock edge with push high and full low. Bytes are row-major, bit 7 the
//   leftmost pixel, rows padded to whole bytes; glyph_start marks a glyph's
//   first byte and restarts at row 0, column 0.
//   Result queue side: while empty is low, rect_item holds the oldest fill
//   command; pop takes it. last_of_byte flags the last command released by
//   a byte. A byte closing a fifth run holds that command back and releases
//   it ahead of the next byte's commands.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register;
//   write only while no commands are outstanding.
// Timing:
//   A taken byte's commands are registered in the queue and reach rect_item
//   once the older records are popped. Bytes are taken one per cycle while
//   full is low; the output side delivers one command per cycle while pop
//   is high. A four-record queue between scanner and output absorbs bursts.
// Reset and stall:
//   rst clears scan state, held command and queue, and restores the default
//   geometry (8 x 8). When pop stays low the queue fills and full rises.
// ----------------------------------------------------------------------------
module glyph_bitmap_run_extractor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  gbre_pkg::in_t                     bitmap_item,
  output logic                              empty,
  input  logic                              pop,
  output gbre_pkg::out_t                    rect_item,
  input  logic                              cfg_write,
  input  logic [gbre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbre_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gbre_pkg::cfg_t cfg;
  gbre_pkg::rec_t wr_rec;
  gbre_pkg::rec_t head;
  logic           wr_en;
  logic           rd_en;
  logic           head_valid;
  logic           accept;

  // An input transaction completes when push meets a free queue slot
  assign accept = push && !full;

  // Register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width  <= gbre_pkg::RESET_GLYPH_WIDTH;
      cfg.glyph_height <= gbre_pkg::RESET_GLYPH_HEIGHT;
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.fill_color   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gbre_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[7:0];
        gbre_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[7:0];
        gbre_pkg::REG_ORIGIN_X:     cfg.origin_x     <= $signed(cfg_data);
        gbre_pkg::REG_ORIGIN_Y:     cfg.origin_y     <= $signed(cfg_data);
        gbre_pkg::REG_FILL_COLOR:   cfg.fill_color   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Scanner: classify the byte into runs and build its command record
  gbre_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (bitmap_item),
    .accept (accept),
    .wr_en  (wr_en),
    .wr_rec (wr_rec)
  );

  // Decouple scanning from delivery
  gbre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_rec     (wr_rec),
    .rd_en      (rd_en),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  // Output side: one command per pop transaction
  gbre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rect_item  (rect_item),
    .empty      (empty),
    .rd_en      (rd_en)
  );

endmodule
